@@ src/skt_pkg.sv @@
// Shared types and constants for the sorted key table.
package skt_pkg;

  localparam int KEY_W = 64;  // key port width
  localparam int POS_W = 7;   // reported position width

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic cmp_en;  // latch compare flags against the working key
    logic ins_en;  // shift up / load the working key
  } skt_cell_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_INS  = 5'b00100,
    ST_SRCH = 5'b01000,
    ST_RESP = 5'b10000
  } skt_state_t;

endpackage

@@ src/sorted_key_table_insert_search_top.sv @@
// Top level of the sorted key table: cell row, control sequencer, result register.
//
//   channel | ports                                    | role
//   --------+------------------------------------------+----------------------------
//   in      | in_valid in_stall in_command in_key      | insert / search word
//   out     | out_valid out_stall out_found            | one result word per command
//           | out_position out_full_drop               |
//
// Steps: insert accepts, compares in every cell in parallel, shifts the row, gives the result;
// a refused insert on a full table skips the shift. Search accepts, compares, then probes
// (at most clog2(count+1) probes) plus one more on a miss to see the window close.
// Reset clears the sequencer, entry count and result valid; stored keys are only
// read below the entry count and need no clearing.
// A stalled result holds the block in its result state; no new word is taken then.
module sorted_key_table_insert_search_top #(
  parameter int TABLE_DEPTH = 128,
  parameter int KEY_BYTES   = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [skt_pkg::KEY_W-1:0] in_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [skt_pkg::POS_W-1:0] out_position,
  output logic                      out_full_drop
);
  import skt_pkg::*;

  localparam int KW = KEY_BYTES * 8;
  localparam int IW = $clog2(TABLE_DEPTH);       // slot index width
  localparam int CW = $clog2(TABLE_DEPTH + 1);   // count width

  skt_state_t state_r, state_nxt;

  logic           cmd_r;
  logic [KW-1:0]  k_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;     // search window [lo, hi_x)
  logic [CW-1:0]  hi_x_r, hi_x_nxt;

  logic           res_found_r, res_found_nxt;
  logic [IW-1:0]  res_idx_r, res_idx_nxt;
  logic           res_drop_r, res_drop_nxt;
  logic           out_valid_r;

  skt_cell_ctrl_t ctrl;

  logic [KW-1:0]  cell_key [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_vec, eq_vec, ld_vec, filled_vec;

  // ---------------- cell row ----------------
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KW-1:0] pk;
    logic          pl;
    if (i == 0) begin : g_head
      assign pk = k_r;
      assign pl = 1'b1;
    end else begin : g_body
      assign pk = cell_key[i-1];
      assign pl = lt_vec[i-1];
    end
    assign filled_vec[i] = (cnt_r > CW'(i));

    skt_cell #(.KW(KW)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .k         (k_r),
      .filled    (filled_vec[i]),
      .prev_key  (pk),
      .prev_lt   (pl),
      .key_r     (cell_key[i]),
      .lt_r      (lt_vec[i]),
      .eq_r      (eq_vec[i]),
      .load_here (ld_vec[i])
    );
  end

  // insert slot: exactly one cell sees the lt edge
  logic [IW-1:0] slot;
  always_comb begin
    slot = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (ld_vec[i]) slot = slot | IW'(i);
    end
  end

  // binary-search probe, floor midpoint of [lo, hi_x-1]
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_w;
  logic [IW-1:0] mid_idx;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_x_r} - (CW+1)'(1);
  assign mid_w   = mid_sum[CW:1];
  assign mid_idx = mid_w[IW-1:0];

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall = (state_r != ST_IDLE);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_x_nxt      = hi_x_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    res_drop_nxt  = res_drop_r;
    ctrl          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        ctrl.cmp_en   = 1'b1;
        res_found_nxt = 1'b0;
        res_idx_nxt   = '0;
        res_drop_nxt  = 1'b0;
        lo_nxt        = '0;
        hi_x_nxt      = cnt_r;
        if (cmd_r == CMD_SEARCH) begin
          state_nxt = ST_SRCH;
        end else if (cnt_r == CW'(TABLE_DEPTH)) begin
          res_drop_nxt = 1'b1;
          state_nxt    = ST_RESP;
        end else begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        ctrl.ins_en = 1'b1;
        res_idx_nxt = slot;
        cnt_nxt     = cnt_r + CW'(1);
        state_nxt   = ST_RESP;
      end
      ST_SRCH: begin
        if (lo_r >= hi_x_r) begin
          state_nxt = ST_RESP;           // miss
        end else if (eq_vec[mid_idx]) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = mid_idx;
          state_nxt     = ST_RESP;
        end else if (lt_vec[mid_idx]) begin
          lo_nxt = mid_w + CW'(1);
        end else begin
          hi_x_nxt = mid_w;
        end
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  logic [POS_W+IW-1:0] pos_ext;
  assign pos_ext = {{POS_W{1'b0}}, res_idx_r};

  logic                out_found_r, out_drop_r;
  logic [POS_W-1:0]    out_pos_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r <= in_command;
      k_r   <= in_key[KW-1:0];
    end
    lo_r        <= lo_nxt;
    hi_x_r      <= hi_x_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_drop_r  <= res_drop_nxt;
    if (state_r == ST_RESP && out_free) begin
      out_found_r <= res_found_r;
      out_pos_r   <= pos_ext[POS_W-1:0];
      out_drop_r  <= res_drop_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_position  = out_pos_r;
  assign out_full_drop = out_drop_r;

endmodule

@@ src/skt_cell.sv @@
// One table slot: stored key, compare flags and shift-up logic.
module skt_cell #(
  parameter int KW = 64
) (
  input  logic                    clk,
  input  skt_pkg::skt_cell_ctrl_t ctrl,
  input  logic [KW-1:0]           k,
  input  logic                    filled,
  input  logic [KW-1:0]           prev_key,
  input  logic                    prev_lt,
  output logic [KW-1:0]           key_r,
  output logic                    lt_r,
  output logic                    eq_r,
  output logic                    load_here
);
  import skt_pkg::*;

  // first slot whose key is not below k, behind a run of smaller keys
  assign load_here = !lt_r && prev_lt;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt_r <= filled && (key_r < k);
      eq_r <= (key_r == k);
    end
    if (ctrl.ins_en && !lt_r) begin
      key_r <= load_here ? k : prev_key;
    end
  end

endmodule

@@ tb/skt_checker.sv @@
// Checker for the sorted key table: tracks the table contents, predicts each result word and compares.
`timescale 1ns / 1ps

module skt_checker #(
  parameter int TABLE_DEPTH = 128,
  parameter int KEY_BYTES   = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_command,
  input  logic [skt_pkg::KEY_W-1:0] in_key,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_found,
  input  logic [skt_pkg::POS_W-1:0] out_position,
  input  logic                      out_full_drop,
  output int                        err_count,
  output int                        pending,
  output int                        n_placed,
  output int                        n_dropped,
  output int                        n_hits,
  output int                        n_misses
);
  import skt_pkg::*;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             full_drop;
  } skt_result_t;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  int               fill;
  skt_result_t      due_q [$];
  skt_result_t      want;

  // Updates the shadow table and returns the result word the command should give.
  function automatic skt_result_t table_op(input logic cmd, input logic [KEY_W-1:0] raw);
    skt_result_t      r;
    logic [KEY_W-1:0] k;
    int               slot;
    int               lo;
    int               hi;
    int               mid;
    r = '0;
    k = raw & KEY_MASK;
    if (cmd == CMD_INSERT) begin
      if (fill >= TABLE_DEPTH) begin
        r.full_drop = 1'b1;
        n_dropped++;
      end else begin
        // lands in front of any equal keys
        slot = 0;
        while (slot < fill && shadow_keys[slot] < k) slot++;
        for (int j = fill; j > slot; j--) shadow_keys[j] = shadow_keys[j-1];
        shadow_keys[slot] = k;
        fill++;
        r.position = slot[POS_W-1:0];
        n_placed++;
      end
    end else begin
      lo = 0;
      hi = fill - 1;
      while (lo <= hi && !r.found) begin
        mid = (lo + hi) / 2;
        if (shadow_keys[mid] == k) begin
          r.found    = 1'b1;
          r.position = mid[POS_W-1:0];
        end else if (shadow_keys[mid] < k) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      if (r.found) n_hits++;
      else n_misses++;
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      due_q.delete();
      fill = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, got found=%0b position=%0d full_drop=%0b",
                   $time, out_found, out_position, out_full_drop);
          err_count++;
        end else begin
          want = due_q.pop_front();
          check_field("found", want.found, out_found);
          check_field("position", want.position, out_position);
          check_field("full_drop", want.full_drop, out_full_drop);
        end
      end
      if (in_valid && !in_stall) due_q.push_back(table_op(in_command, in_key));
    end
    pending = due_q.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the sorted key table: clock, reset, command stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module tb;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int KEY_BYTES   = 8;
  localparam int N_RANDOM    = 1700;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_command;
  logic [KEY_W-1:0]     in_key;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_found;
  logic [POS_W-1:0]     out_position;
  logic                 out_full_drop;

  int chk_errors;
  int chk_pending;
  int n_placed;
  int n_dropped;
  int n_hits;
  int n_misses;

  // Words accepted so far; the sender runs gap-free while this is in 400..699.
  int               words_sent;
  // Keys that actually went into the table, so searches can aim for hits.
  logic [KEY_W-1:0] stored_keys [$];
  int               inserts_sent;

  sorted_key_table_insert_search_top #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_position  (out_position),
    .out_full_drop (out_full_drop)
  );

  skt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_position  (out_position),
    .out_full_drop (out_full_drop),
    .err_count     (chk_errors),
    .pending       (chk_pending),
    .n_placed      (n_placed),
    .n_dropped     (n_dropped),
    .n_hits        (n_hits),
    .n_misses      (n_misses)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, long enough for the long result hold-off and every gap at its worst.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Printable string of 1..KEY_BYTES chars, first char in the top byte, zero padded.
  function automatic logic [KEY_W-1:0] str_key();
    logic [KEY_W-1:0] k;
    int               len;
    k   = '0;
    len = $urandom_range(1, KEY_BYTES);
    for (int b = 0; b < len; b++) k[KEY_W-1-8*b -: 8] = 8'($urandom_range(8'h20, 8'h7e));
    return k;
  endfunction

  // Offer one word and hold it until taken. Called at a rising edge, returns
  // at the edge where the word was accepted. A random gap goes in front of
  // about 30% of the words, except through the gap-free stretch.
  task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key);
    int gap;
    gap = 0;
    if (!(words_sent >= 400 && words_sent < 700) && $urandom_range(99) < 30)
      gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (cmd == CMD_INSERT) begin
      if (inserts_sent < TABLE_DEPTH) stored_keys.push_back(key);
      inserts_sent++;
    end
  endtask

  // Result side. Stalls in about 30% of cycles, except for:
  //   - a hold-off early on, so the block backs up and stalls input
  //   - a quiet stretch with no stalls at all
  initial begin
    int cyc;
    cyc = 0;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 2500 && cyc < 2900)
        out_stall <= 1'b1;
      else if (cyc >= 9000 && cyc < 13000)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(99) < 30);
    end
  end

  initial begin
    logic             cmd;
    logic [KEY_W-1:0] key;
    int               sel;

    words_sent   = 0;
    inserts_sent = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_INSERT;
    in_key     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: searches on an empty table, extreme keys, duplicates (insert
    // goes in front of the equal ones), hits and misses between stored keys.
    send_word(CMD_SEARCH, 64'h0);
    send_word(CMD_SEARCH, {KEY_W{1'b1}});
    send_word(CMD_INSERT, 64'h4142_0000_0000_0000);  // "AB"
    send_word(CMD_INSERT, 64'h0);
    send_word(CMD_INSERT, {KEY_W{1'b1}});
    send_word(CMD_INSERT, 64'h4142_0000_0000_0000);  // duplicate "AB"
    send_word(CMD_INSERT, 64'h4100_0000_0000_0000);  // "A" sorts before "AB"
    send_word(CMD_SEARCH, 64'h0);
    send_word(CMD_SEARCH, {KEY_W{1'b1}});
    send_word(CMD_SEARCH, 64'h4142_0000_0000_0000);
    send_word(CMD_SEARCH, 64'h4142_4300_0000_0000);  // "ABC" miss
    send_word(CMD_SEARCH, 64'h4100_0000_0000_0000);
    send_word(CMD_INSERT, 64'h8000_0000_0000_0000);
    send_word(CMD_INSERT, 64'h1);
    send_word(CMD_SEARCH, 64'h7fff_ffff_ffff_ffff);  // falls between two keys
    send_word(CMD_SEARCH, 64'h1);
    send_word(CMD_SEARCH, 64'h8000_0000_0000_0000);
    send_word(CMD_INSERT, {KEY_W{1'b1}});            // duplicate at the top end
    send_word(CMD_SEARCH, {KEY_W{1'b1}});
    send_word(CMD_INSERT, 64'h0);                    // duplicate at the bottom end
    send_word(CMD_SEARCH, 64'h0);
    send_word(CMD_SEARCH, 64'h2);

    // Random: about one insert in five, so the table fills part way through
    // and later inserts hit the full-table drop while searches go on.
    // Keys mix full random words, short strings, stored keys (hits and
    // duplicates) and their neighbors (near misses).
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 900) begin
        // sender goes quiet until every result is back; the count is read
        // mid-cycle so the word accepted at this edge is already counted
        in_valid <= 1'b0;
        @(negedge clk);
        while (chk_pending != 0) @(negedge clk);
        @(posedge clk);
      end
      cmd = ($urandom_range(99) < 22) ? CMD_INSERT : CMD_SEARCH;
      sel = $urandom_range(99);
      if (stored_keys.size() == 0 || sel < 30) begin
        key = {$urandom, $urandom};
      end else if (sel < 50) begin
        key = str_key();
      end else begin
        key = stored_keys[$urandom_range(stored_keys.size() - 1)];
        if (sel < 70) key = $urandom_range(1) ? key + 64'd1 : key - 64'd1;
      end
      send_word(cmd, key);
    end
    in_valid <= 1'b0;

    // Drain, then give the block a search's worth of cycles for anything stray.
    @(negedge clk);
    while (chk_pending != 0) @(negedge clk);
    repeat (16) @(posedge clk);

    $display("Run covered %0d commands: %0d keys placed, %0d inserts refused on a full table.",
             words_sent, n_placed, n_dropped);
    $display("Searches: %0d hits, %0d misses.", n_hits, n_misses);
    if (chk_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/skt_pkg.sv
src/skt_cell.sv
src/sorted_key_table_insert_search_top.sv
tb/skt_checker.sv
tb/tb.sv
